@@ sv/rbd_pkg.sv @@
// Package for the Rice block decoder: sizes, register indexes, status codes,
// state type and the command and status bundles between controller and datapath.
// No dependencies.
package rbd_pkg;

    localparam int COORDS = 256;
    localparam int MAX_K  = 31;
    localparam int NSUM   = MAX_K + 1;
    localparam int CNT_W  = $clog2(COORDS + 1);
    localparam int IDX_W  = 8;
    localparam int VAL_W  = 32;
    localparam int K_W    = 5;
    localparam int BC_W   = 37;
    localparam int SUM_W  = 41;
    localparam int SIDX_W = $clog2(NSUM);

    localparam logic [1:0] CFG_RICE_K   = 2'd0;
    localparam logic [1:0] CFG_EXACT    = 2'd1;
    localparam logic [1:0] CFG_CHECK_K  = 2'd2;

    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_TRUNC    = 3'd1;
    localparam logic [2:0] STAT_OVERFLOW = 3'd2;
    localparam logic [2:0] STAT_PADDING  = 3'd3;
    localparam logic [2:0] STAT_TRAILING = 3'd4;
    localparam logic [2:0] STAT_NOT_OPT  = 3'd5;

    localparam logic KIND_COORD  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BIT,
        ST_SCAN,
        ST_FINISH,
        ST_CLOSE
    } t_state;

    typedef struct packed {
        logic       load;
        logic       bit_step;
        logic       scan_init;
        logic       scan_step;
        logic       push_status;
        logic [2:0] code;
        logic       flush;
        logic       clear_block;
    } t_cmd;

    typedef struct packed {
        logic go;
        logic coord;
        logic ovf;
        logic full;
        logic pad_nz;
        logic scan_last;
        logic kopt;
        logic last;
        logic exact;
        logic chk;
    } t_stat;

    typedef struct packed {
        logic             kind;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] value;
        logic [2:0]       status;
        logic [BC_W-1:0]  bytes;
        logic             eor;
    } t_result;

endpackage

@@ sv/rice_block_decoder.sv @@
// Rice block decoder top level: a byte-stream Golomb-Rice decoder with
// zigzag inverse for one block of coordinates. Each byte is taken, decoded one bit per
// cycle while the output is free, and closed; a byte that ends the block stops at the bit
// that ends it, then runs the optimal-k scan when enabled and pushes the status before the
// close. A new byte is not taken until the current one is closed (o_in_stall while busy).
// Sync active-low reset, k=0 exact=1 check=1.
module rice_block_decoder
    import rbd_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [1:0]              i_cfg_idx,
    input  logic [K_W-1:0]          i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [7:0]              i_data_byte,
    input  logic                    i_last_byte,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic                    o_item_kind,
    output logic [IDX_W-1:0]        o_coord_index,
    output logic signed [VAL_W-1:0] o_coord_value,
    output logic [2:0]              o_status,
    output logic [BC_W-1:0]         o_bytes_consumed,
    output logic                    o_end_of_run
);

    t_cmd    cmd;
    t_stat   stat;
    t_result res;

    rbd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last_byte (i_last_byte),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall)
    );

    rbd_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out       (res),
        .o_out_valid (o_out_valid)
    );

    assign o_item_kind      = res.kind;
    assign o_coord_index    = res.idx;
    assign o_coord_value    = res.value;
    assign o_status         = res.status;
    assign o_bytes_consumed = res.bytes;
    assign o_end_of_run     = res.eor;

endmodule

@@ sv/rbd_ctrl.sv @@
// Controller of the Rice block decoder: walks each byte bit by bit, runs the
// optimal-k scan and orders result and status delivery. Uses rbd_pkg.
module rbd_ctrl
    import rbd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_last_byte,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_in_stall
);

    t_state     r_state, n_state;
    logic [2:0] r_bit, n_bit;
    logic [2:0] r_code, n_code;
    logic       r_had, n_had;
    logic       r_skip, n_skip;
    logic       accept;

    assign accept = i_in_valid && (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        n_bit   = r_bit;
        n_code  = r_code;
        n_had   = r_had;
        n_skip  = r_skip;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (r_skip) begin
                        if (i_last_byte) n_skip = 1'b0;
                    end else begin
                        n_state = ST_BIT;
                        n_bit   = 3'd0;
                        n_had   = 1'b0;
                    end
                end
            end
            ST_BIT: begin
                if (i_stat.go) begin
                    priority if (i_stat.ovf) begin
                        n_code  = STAT_OVERFLOW;
                        n_had   = 1'b1;
                        n_state = ST_FINISH;
                    end else if (i_stat.coord && i_stat.full) begin
                        n_had = 1'b1;
                        priority if (i_stat.pad_nz) begin
                            n_code  = STAT_PADDING;
                            n_state = ST_FINISH;
                        end else if (i_stat.exact && !i_stat.last) begin
                            n_code  = STAT_TRAILING;
                            n_state = ST_FINISH;
                        end else if (i_stat.chk) begin
                            n_state = ST_SCAN;
                        end else begin
                            n_code  = STAT_OK;
                            n_state = ST_FINISH;
                        end
                    end else if (r_bit == 3'd7) begin
                        if (i_stat.last) begin
                            n_code  = STAT_TRUNC;
                            n_had   = 1'b1;
                            n_state = ST_FINISH;
                        end else begin
                            n_state = ST_CLOSE;
                        end
                    end else begin
                        n_bit = r_bit + 3'd1;
                    end
                end
            end
            ST_SCAN: begin
                if (i_stat.scan_last) begin
                    n_code  = i_stat.kopt ? STAT_OK : STAT_NOT_OPT;
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (i_stat.go) n_state = ST_CLOSE;
            end
            ST_CLOSE: begin
                if (i_stat.go) begin
                    n_state = ST_IDLE;
                    if (r_had && !i_stat.last) n_skip = 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.code = r_code;
        o_in_stall = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.load        = accept && !r_skip;
                o_cmd.clear_block = accept && r_skip && i_last_byte;
            end
            ST_BIT: begin
                o_cmd.bit_step  = i_stat.go;
                o_cmd.scan_init = i_stat.go;
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
            end
            ST_FINISH: begin
                o_cmd.push_status = i_stat.go;
            end
            ST_CLOSE: begin
                o_cmd.flush       = i_stat.go;
                o_cmd.clear_block = i_stat.go && r_had && i_stat.last;
            end
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_bit   <= 3'd0;
            r_code  <= STAT_OK;
            r_had   <= 1'b0;
            r_skip  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_bit   <= n_bit;
            r_code  <= n_code;
            r_had   <= n_had;
            r_skip  <= n_skip;
        end
    end

`ifndef NO_ASSERTIONS
    a_skip_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skip |-> r_state == ST_IDLE)
        else $error("skip phase outside idle");
    a_scan_had: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SCAN |-> r_had)
        else $error("scan without block end");
    a_finish_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_FINISH && i_stat.go |=> r_state == ST_CLOSE)
        else $error("status not followed by close");
`endif

endmodule

@@ sv/rbd_dpath.sv @@
// Datapath of the Rice block decoder: bit-serial quotient and remainder
// decode, zigzag, cost accumulators, scan and result registers. Uses rbd_pkg.
module rbd_dpath
    import rbd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [K_W-1:0]   i_cfg_data,
    input  logic [7:0]       i_data_byte,
    input  logic             i_last_byte,
    input  logic             i_out_stall,
    input  t_cmd             i_cmd,
    output t_stat            o_stat,
    output t_result          o_out,
    output logic             o_out_valid
);

    logic [K_W-1:0]    r_k;
    logic              r_exact, r_chk;
    logic [7:0]        r_byte;
    logic              r_last;
    logic              r_inrem;
    logic [VAL_W:0]    r_q;
    logic [VAL_W-1:0]  r_rem;
    logic [K_W-1:0]    r_rdone;
    logic [CNT_W-1:0]  r_coords;
    logic [BC_W-1:0]   r_bytes;
    logic [SUM_W-1:0]  r_sums [NSUM];
    logic [SIDX_W-1:0] r_sidx, r_best;
    logic [SUM_W-1:0]  r_best_val;
    t_result           r_pend, r_out;
    logic              r_pend_valid, r_out_valid;

    logic              bitv, out_free, go, coord, ovf_q, ovf_x, full;
    logic [VAL_W:0]    q_inc, lim;
    logic [VAL_W-1:0]  rem_n, x, zz;
    logic [K_W:0]      done_n;
    logic [63:0]       x64;
    logic [CNT_W:0]    coords_inc;
    logic [SIDX_W-1:0] best_n;
    logic              push;
    t_result           new_res;

    assign bitv     = r_byte[0];
    assign out_free = !r_out_valid || !i_out_stall;
    assign go       = !r_pend_valid || out_free;
    assign q_inc    = r_q + 1'b1;
    assign lim      = {1'b0, 32'hFFFF_FFFF >> r_k};
    assign rem_n    = r_rem | (VAL_W'(bitv) << r_rdone);
    assign done_n   = {1'b0, r_rdone} + 1'b1;

    always_comb begin
        coord = 1'b0;
        ovf_q = 1'b0;
        if (!r_inrem) begin
            if (bitv) ovf_q = (q_inc > lim);
            else      coord = (r_k == '0);
        end else begin
            coord = (done_n >= {1'b0, r_k});
        end
    end

    assign x64        = (64'(r_q) << r_k) | 64'(r_inrem ? rem_n : '0);
    assign ovf_x      = |x64[63:VAL_W];
    assign x          = x64[VAL_W-1:0];
    assign zz         = (x >> 1) ^ (VAL_W'(0) - VAL_W'(x[0]));
    assign coords_inc = {1'b0, r_coords} + 1'b1;
    assign full       = coords_inc >= (CNT_W+1)'(COORDS);
    assign best_n     = (r_sums[r_sidx] < r_best_val) ? r_sidx : r_best;

    assign o_stat.go        = go;
    assign o_stat.coord     = coord && !ovf_x;
    assign o_stat.ovf       = ovf_q || (coord && ovf_x);
    assign o_stat.full      = full;
    assign o_stat.pad_nz    = |r_byte[7:1];
    assign o_stat.scan_last = (r_sidx == SIDX_W'(MAX_K));
    assign o_stat.kopt      = (K_W'(best_n) == r_k);
    assign o_stat.last      = r_last;
    assign o_stat.exact     = r_exact;
    assign o_stat.chk       = r_chk;

    always_comb begin
        new_res = '0;
        push    = 1'b0;
        if (i_cmd.bit_step && coord && !ovf_x) begin
            push          = 1'b1;
            new_res.kind  = KIND_COORD;
            new_res.idx   = IDX_W'(r_coords);
            new_res.value = zz;
            new_res.bytes = r_bytes;
        end else if (i_cmd.push_status) begin
            push           = 1'b1;
            new_res.kind   = KIND_STATUS;
            new_res.status = i_cmd.code;
            new_res.bytes  = r_bytes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k     <= '0;
            r_exact <= 1'b1;
            r_chk   <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RICE_K:  r_k     <= i_cfg_data;
                CFG_EXACT:   r_exact <= i_cfg_data[0];
                CFG_CHECK_K: r_chk   <= i_cfg_data[0];
                default:     r_k     <= r_k;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_block) begin
            r_inrem  <= 1'b0;
            r_q      <= '0;
            r_rem    <= '0;
            r_rdone  <= '0;
            r_coords <= '0;
            r_bytes  <= '0;
            for (int j = 0; j < NSUM; j++) r_sums[j] <= '0;
        end else if (i_cmd.load) begin
            if (r_bytes != '1) r_bytes <= r_bytes + 1'b1;
        end else if (i_cmd.bit_step) begin
            if (coord) begin
                r_inrem  <= 1'b0;
                r_q      <= '0;
                r_rem    <= '0;
                r_rdone  <= '0;
                r_coords <= r_coords + 1'b1;
                for (int j = 0; j < NSUM; j++)
                    r_sums[j] <= r_sums[j] + SUM_W'(x >> j) + SUM_W'(j) + 1'b1;
            end else if (!r_inrem) begin
                if (bitv) r_q <= q_inc;
                else      r_inrem <= 1'b1;
            end else begin
                r_rem   <= rem_n;
                r_rdone <= done_n[K_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_byte <= i_data_byte;
            r_last <= i_last_byte;
        end else if (i_cmd.bit_step) begin
            r_byte <= {1'b0, r_byte[7:1]};
        end
        if (i_cmd.scan_init) begin
            r_sidx     <= '0;
            r_best     <= '0;
            r_best_val <= '1;
        end else if (i_cmd.scan_step) begin
            r_sidx     <= r_sidx + 1'b1;
            r_best     <= best_n;
            r_best_val <= r_sums[r_sidx] < r_best_val ? r_sums[r_sidx] : r_best_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (push) begin
                r_pend       <= new_res;
                r_pend_valid <= 1'b1;
                if (r_pend_valid) begin
                    r_out       <= r_pend;
                    r_out_valid <= 1'b1;
                end else if (!i_out_stall) begin
                    r_out_valid <= 1'b0;
                end
            end else if (i_cmd.flush && r_pend_valid) begin
                r_out        <= r_pend;
                r_out.eor    <= 1'b1;
                r_out_valid  <= 1'b1;
                r_pend_valid <= 1'b0;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out       = r_out;
    assign o_out_valid = r_out_valid;

`ifndef NO_ASSERTIONS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push || i_cmd.flush) && r_pend_valid |-> out_free)
        else $error("result register overwritten");
    a_coords_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_coords <= CNT_W'(COORDS))
        else $error("coordinate count past block size");
    a_coord_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.kind == KIND_COORD |-> r_out.status == STAT_OK)
        else $error("coordinate item carries a status");
`endif

endmodule

@@ dv/tb_rice_block_decoder.sv @@
// Self-checking testbench for rice_block_decoder: encoded byte streams in,
// decoded coordinates and block status out, checked against a built-in predictor.
// Depends on rbd_pkg and the rice_block_decoder RTL.
module tb_rice_block_decoder;
    import rbd_pkg::*;

    localparam int ITEM_TARGET = 280;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 60;

    typedef struct packed {
        bit        kind;
        bit [7:0]  idx;
        bit [31:0] val;
        bit [2:0]  stat;
        bit [36:0] bytes;
        bit        eor;
    } t_rice_out;

    class rice_scoreboard;
        bit [4:0]        k_reg;
        bit              exact_reg;
        bit              check_reg;
        bit              in_rem;
        longint unsigned quot;
        bit [31:0]       rem_val;
        int              rem_done;
        int              coord_cnt;
        bit [36:0]       byte_cnt;
        bit              skipping;
        longint unsigned cost_sum[MAX_K+1];
        t_rice_out       expected_q[$];
        int              errors;
        int              coords_seen;
        int              status_seen;

        function new();
            k_reg = 0;
            exact_reg = 1;
            check_reg = 1;
            errors = 0;
            coords_seen = 0;
            status_seen = 0;
            clear_block();
        endfunction

        function void clear_block();
            in_rem = 0;
            quot = 0;
            rem_val = 0;
            rem_done = 0;
            coord_cnt = 0;
            byte_cnt = 0;
            skipping = 0;
            foreach (cost_sum[j]) cost_sum[j] = 0;
        endfunction

        function void set_reg(bit [1:0] idx, bit [4:0] v);
            if (idx == CFG_RICE_K) k_reg = v;
            else if (idx == CFG_EXACT) exact_reg = v[0];
            else if (idx == CFG_CHECK_K) check_reg = v[0];
        endfunction

        function bit k_optimal();
            int best;
            best = 0;
            for (int j = 1; j <= MAX_K; j++)
                if (cost_sum[j] < cost_sum[best]) best = j;
            return k_reg == best;
        endfunction

        function t_rice_out make_out(bit kind, bit [7:0] idx, bit [31:0] v, bit [2:0] s);
            t_rice_out r;
            r.kind = kind;
            r.idx = idx;
            r.val = v;
            r.stat = s;
            r.bytes = byte_cnt;
            r.eor = 0;
            return r;
        endfunction

        function void note_byte(bit [7:0] b, bit lst);
            t_rice_out       outs[$];
            int              st;
            bit              bt;
            longint unsigned x;
            bit [31:0]       xv;
            st = -1;
            if (skipping) begin
                if (lst) clear_block();
                return;
            end
            if (byte_cnt != '1) byte_cnt++;
            for (int i = 0; i < 8; i++) begin
                bt = b[i];
                if (!in_rem) begin
                    if (bt) begin
                        quot++;
                        if (quot > (64'hFFFF_FFFF >> k_reg)) begin
                            st = STAT_OVERFLOW;
                            break;
                        end
                        continue;
                    end
                    if (k_reg != 0) begin
                        in_rem = 1;
                        continue;
                    end
                end else begin
                    rem_val[rem_done[4:0]] = rem_val[rem_done[4:0]] | bt;
                    rem_done++;
                    if (rem_done < k_reg) continue;
                end
                x = (quot << k_reg) | rem_val;
                in_rem = 0;
                quot = 0;
                rem_val = 0;
                rem_done = 0;
                if (x > 64'hFFFF_FFFF) begin
                    st = STAT_OVERFLOW;
                    break;
                end
                for (int j = 0; j <= MAX_K; j++) cost_sum[j] += (x >> j) + 1 + j;
                xv = x[31:0];
                outs.push_back(make_out(KIND_COORD, coord_cnt[7:0],
                                        (xv >> 1) ^ {32{xv[0]}}, STAT_OK));
                coord_cnt++;
                if (coord_cnt >= COORDS) begin
                    if ((b >> (i + 1)) != 0) st = STAT_PADDING;
                    else if (exact_reg && !lst) st = STAT_TRAILING;
                    else if (check_reg && !k_optimal()) st = STAT_NOT_OPT;
                    else st = STAT_OK;
                    break;
                end
            end
            if (st < 0 && lst) st = STAT_TRUNC;
            if (st >= 0) begin
                outs.push_back(make_out(KIND_STATUS, 0, 0, st[2:0]));
                if (lst) clear_block();
                else skipping = 1;
            end
            if (outs.size() > 0) outs[outs.size()-1].eor = 1;
            foreach (outs[n]) expected_q.push_back(outs[n]);
        endfunction

        function void check_result(t_rice_out got);
            t_rice_out want;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: kind %0d idx %0d val %h stat %0d",
                             got.kind, got.idx, got.val, got.stat);
                return;
            end
            want = expected_q.pop_front();
            if (got.kind) status_seen++;
            else coords_seen++;
            if (got != want) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch: exp kind %0d idx %0d val %h stat %0d bytes %0d eor %0d",
                             want.kind, want.idx, want.val, want.stat, want.bytes, want.eor);
                    $display("          got kind %0d idx %0d val %h stat %0d bytes %0d eor %0d",
                             got.kind, got.idx, got.val, got.stat, got.bytes, got.eor);
                end
            end
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [1:0]              i_cfg_idx;
    logic [K_W-1:0]          i_cfg_data;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic [7:0]              i_data_byte;
    logic                    i_last_byte;
    logic                    o_out_valid;
    logic                    i_out_stall;
    logic                    o_item_kind;
    logic [IDX_W-1:0]        o_coord_index;
    logic signed [VAL_W-1:0] o_coord_value;
    logic [2:0]              o_status;
    logic [BC_W-1:0]         o_bytes_consumed;
    logic                    o_end_of_run;

    rice_block_decoder dut (.*);

    rice_scoreboard sb = new();
    int             send_idle_pct;
    int             recv_idle_pct;
    int             bytes_sent;
    int             cycle_cnt;
    bit [7:0]       blk_bytes[$];
    bit             blk_last[$];

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(negedge i_clk)
        i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);

    always @(posedge i_clk) begin
        t_rice_out got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.kind = o_item_kind;
            got.idx = o_coord_index;
            got.val = o_coord_value;
            got.stat = o_status;
            got.bytes = o_bytes_consumed;
            got.eor = o_end_of_run;
            sb.check_result(got);
        end
    end

    task automatic send_byte(bit [7:0] b, bit lst);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 0;
            @(negedge i_clk);
        end
        i_in_valid <= 1;
        i_data_byte <= b;
        i_last_byte <= lst;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_byte(b, lst);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_in_valid <= 0;
        @(negedge i_clk);
        while (sb.expected_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(bit [1:0] idx, bit [4:0] v);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        sb.set_reg(idx, v);
        @(negedge i_clk);
        i_cfg_we <= 0;
    endtask

    function automatic void build_block(int k, int mode);
        bit        bits[$];
        int        x;
        int        q;
        int        keep;
        int        pos;
        bit [7:0]  b;
        blk_bytes.delete();
        blk_last.delete();
        for (int c = 0; c < COORDS; c++) begin
            x = (k >= 30) ? $urandom : $urandom_range(0, (3 << k) - 1);
            q = int'(x >>> k) & ((k >= 30) ? 3 : 32'h7FFF_FFFF);
            if (k >= 30) q = int'({32'b0, x} >> k);
            repeat (q) bits.push_back(1);
            bits.push_back(0);
            for (int i = 0; i < k; i++) bits.push_back(x[i]);
        end
        pos = bits.size();
        while (bits.size() % 8 != 0) bits.push_back(0);
        if (mode == 2 && pos < bits.size())
            bits[$urandom_range(pos, bits.size() - 1)] = 1;
        for (int i = 0; i < bits.size(); i += 8) begin
            for (int j = 0; j < 8; j++) b[j] = bits[i + j];
            blk_bytes.push_back(b);
        end
        if (mode == 3) repeat ($urandom_range(1, 3)) blk_bytes.push_back(8'($urandom));
        if (mode == 4) blk_bytes[$urandom_range(0, blk_bytes.size() - 1)][$urandom_range(0, 7)] ^= 1;
        if (mode == 1 || k > 3) begin
            keep = $urandom_range(1, (blk_bytes.size() > 20) ? 20 : blk_bytes.size());
            while (blk_bytes.size() > keep) void'(blk_bytes.pop_back());
        end
        foreach (blk_bytes[i]) blk_last.push_back(i == blk_bytes.size() - 1);
    endfunction

    initial begin
        int k;
        int mode;
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_idx = 0;
        i_cfg_data = 0;
        i_in_valid = 0;
        i_data_byte = 0;
        i_last_byte = 0;
        i_out_stall = 0;
        send_idle_pct = 36;
        recv_idle_pct = 86;
        bytes_sent = 0;
        cycle_cnt = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        send_byte(8'h00, 1);
        send_byte(8'hFF, 1);
        send_byte(8'h55, 0);
        send_byte(8'hAA, 1);
        wait_idle();
        write_reg(CFG_RICE_K, 5'd31);
        send_byte(8'hFF, 0);
        send_byte(8'h12, 0);
        send_byte(8'h00, 1);
        send_byte(8'hFD, 0);
        send_byte(8'hFF, 0);
        send_byte(8'hFF, 0);
        send_byte(8'hFF, 0);
        send_byte(8'h01, 1);
        wait_idle();
        write_reg(CFG_EXACT, 5'd0);
        write_reg(CFG_CHECK_K, 5'd0);
        send_byte(8'hFE, 0);
        send_byte(8'h7F, 1);

        for (int p = 0; p < 3; p++) begin
            send_idle_pct = (p == 0) ? 36 : (p == 1) ? 86 : 0;
            recv_idle_pct = (p == 0) ? 86 : (p == 1) ? 36 : 0;
            while (bytes_sent < ITEM_TARGET * (p + 1) / 3) begin
                wait_idle();
                case ($urandom_range(0, 9))
                    0:       k = 31;
                    1:       k = $urandom_range(2, 30);
                    2, 3, 4: k = 1;
                    default: k = 0;
                endcase
                write_reg(CFG_RICE_K, k[4:0]);
                write_reg(CFG_EXACT, 5'($urandom_range(0, 1)));
                write_reg(CFG_CHECK_K, 5'($urandom_range(0, 1)));
                if ($urandom_range(0, 4) == 0) begin
                    repeat ($urandom_range(3, 6))
                        send_byte(8'($urandom), $urandom_range(0, 3) == 0);
                    send_byte(8'($urandom), 1);
                end else begin
                    mode = $urandom_range(0, 7);
                    if (mode > 4) mode = 0;
                    build_block(k, mode);
                    foreach (blk_bytes[i]) send_byte(blk_bytes[i], blk_last[i]);
                end
            end
        end
        wait_idle();

        $display("sent %0d bytes; checked %0d coordinates and %0d block statuses",
                 bytes_sent, sb.coords_seen, sb.status_seen);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.errors, sb.expected_q.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
